>>> sv/wrop_pkg.sv
package wrop_pkg;

  // Fixed sizes of the selection logic.
  localparam int unsigned MaxEntries = 8;
  localparam int unsigned WeightBits = 8;
  localparam int unsigned CountW     = 4;
  localparam int unsigned IdxW       = 3;
  localparam int unsigned RandW      = 31;
  localparam int unsigned TableW     = 64;
  localparam int unsigned SumW       = 11;
  localparam int unsigned DivCntW    = 5;
  localparam int unsigned CfgIdxW    = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_ENABLED      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PLAY_FIRST   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_RANDOMIZE    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ENTRY_COUNT  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_USE_WEIGHTS  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_WEIGHT_TABLE = 3'd5;

  // Controller states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SUM    = 5'b00010,
    S_DIV    = 5'b00100,
    S_WALK   = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  // Source of the result register.
  typedef enum logic [1:0] {
    RES_HOLD = 2'd0,
    RES_NONE = 2'd1,
    RES_ZERO = 2'd2,
    RES_SEQ  = 2'd3
  } res_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    logic     sum_step;
    logic     div_step;
    logic     walk_step;
    logic     push;
    res_sel_e res_sel;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode_none;
    logic mode_first;
    logic mode_rand_w;
    logic mode_rand;
    logic sum_last;
    logic div_last;
    logic walk_done;
    logic out_free;
  } status_t;

endpackage

>>> sv/weighted_random_or_round_robin_pick.sv
// Path from an accepted item to its result: with no pick, play first or round robin the result
// is set when the item is taken and then pushed out; an unweighted random pick first runs the
// remainder steps; a weighted pick sums the weights of the n entries, runs the remainder steps
// and walks k (1..n) entries. One item at a time; a 31-step remainder unit for random modes.
// Reset clears all configuration registers, the round-robin position and the output valid.
module weighted_random_or_round_robin_pick (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wrop_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [wrop_pkg::TableW-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [wrop_pkg::RandW-1:0]    random_value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          pick_valid_o,
  output logic [wrop_pkg::IdxW-1:0]     pick_index_o
);

  wrop_pkg::cmd_t    cmd;
  wrop_pkg::status_t status;

  // Sequencer for one item.
  wrop_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Registers, remainder unit, weight walk and output register.
  wrop_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .random_value_i (random_value_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .pick_valid_o   (pick_valid_o),
    .pick_index_o   (pick_index_o),
    .cmd_i          (cmd),
    .status_o       (status)
  );

endmodule

>>> sv/wrop_ctrl.sv
module wrop_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  wrop_pkg::status_t status_i,
  output wrop_pkg::cmd_t    cmd_o
);

  wrop_pkg::state_e state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.res_sel = wrop_pkg::RES_HOLD;
    unique case (state_q)
      wrop_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          priority if (status_i.mode_none) begin
            cmd_o.res_sel = wrop_pkg::RES_NONE;
            state_d       = wrop_pkg::S_FINISH;
          end else if (status_i.mode_first) begin
            cmd_o.res_sel = wrop_pkg::RES_ZERO;
            state_d       = wrop_pkg::S_FINISH;
          end else if (status_i.mode_rand_w) begin
            state_d = wrop_pkg::S_SUM;
          end else if (status_i.mode_rand) begin
            state_d = wrop_pkg::S_DIV;
          end else begin
            cmd_o.res_sel = wrop_pkg::RES_SEQ;
            state_d       = wrop_pkg::S_FINISH;
          end
        end
      end
      wrop_pkg::S_SUM: begin
        cmd_o.sum_step = 1'b1;
        if (status_i.sum_last) begin
          state_d = wrop_pkg::S_DIV;
        end
      end
      wrop_pkg::S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = status_i.mode_rand_w ? wrop_pkg::S_WALK : wrop_pkg::S_FINISH;
        end
      end
      wrop_pkg::S_WALK: begin
        cmd_o.walk_step = 1'b1;
        if (status_i.walk_done) begin
          state_d = wrop_pkg::S_FINISH;
        end
      end
      wrop_pkg::S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = wrop_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = wrop_pkg::S_IDLE;
      end
    endcase
  end

  // A new item is taken only between requests.
  assign in_stall_o = (state_q != wrop_pkg::S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wrop_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> sv/wrop_dp.sv
module wrop_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [wrop_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [wrop_pkg::TableW-1:0]       cfg_data_i,
  input  logic [wrop_pkg::RandW-1:0]        random_value_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic                              pick_valid_o,
  output logic [wrop_pkg::IdxW-1:0]         pick_index_o,
  input  wrop_pkg::cmd_t                    cmd_i,
  output wrop_pkg::status_t                 status_o
);

  localparam logic [wrop_pkg::CountW-1:0]  MaxCount = wrop_pkg::CountW'(wrop_pkg::MaxEntries);
  localparam logic [wrop_pkg::DivCntW-1:0] DivLast  = wrop_pkg::DivCntW'(wrop_pkg::RandW - 1);

  // Configuration registers.
  logic                            enabled_q;
  logic                            play_first_q;
  logic                            randomize_q;
  logic [wrop_pkg::CountW-1:0]     entry_count_q;
  logic                            use_weights_q;
  logic [wrop_pkg::TableW-1:0]     weight_table_q;

  // Working registers.
  logic [wrop_pkg::IdxW-1:0]       seq_q;
  logic [wrop_pkg::RandW-1:0]      rand_q;
  logic [wrop_pkg::SumW-1:0]       sum_q;
  logic [wrop_pkg::SumW-1:0]       rem_q;
  logic [wrop_pkg::DivCntW-1:0]    div_cnt_q;
  logic [wrop_pkg::IdxW-1:0]       ent_q;
  logic                            res_valid_q;
  logic [wrop_pkg::IdxW-1:0]       res_idx_q;
  logic                            out_valid_q;
  logic                            pick_valid_q;
  logic [wrop_pkg::IdxW-1:0]       pick_index_q;

  logic [wrop_pkg::CountW-1:0]     count;
  logic                            mode_none;
  logic                            mode_first;
  logic                            entry_last;
  logic [wrop_pkg::WeightBits-1:0] weight;
  logic [wrop_pkg::SumW-1:0]       divisor;
  logic [wrop_pkg::SumW:0]         rem_shift;
  logic [wrop_pkg::SumW:0]         rem_diff;
  logic [wrop_pkg::SumW-1:0]       rem_next;
  logic                            walk_hit;
  logic [wrop_pkg::IdxW-1:0]       seq_cur;
  logic [wrop_pkg::CountW-1:0]     seq_inc;

  // Active entry count and mode decode.
  assign count      = (entry_count_q > MaxCount) ? MaxCount : entry_count_q;
  assign mode_none  = !enabled_q || (count == '0);
  assign mode_first = !mode_none && play_first_q;

  assign status_o.mode_none   = mode_none;
  assign status_o.mode_first  = mode_first;
  assign status_o.mode_rand_w = !mode_none && !play_first_q && randomize_q && use_weights_q;
  assign status_o.mode_rand   = !mode_none && !play_first_q && randomize_q && !use_weights_q;

  // Weight of the entry under the walk pointer.
  assign weight     = weight_table_q[ent_q*wrop_pkg::WeightBits +: wrop_pkg::WeightBits];
  assign entry_last = ({1'b0, ent_q} == (count - 4'd1));

  assign status_o.sum_last = entry_last;

  // One restoring step of the remainder, taking the next random bit.
  assign divisor   = use_weights_q ? sum_q : {{(wrop_pkg::SumW-wrop_pkg::CountW){1'b0}}, count};
  assign rem_shift = {rem_q, rand_q[wrop_pkg::RandW-1]};
  assign rem_diff  = rem_shift - {1'b0, divisor};
  assign rem_next  = (rem_shift >= {1'b0, divisor}) ? rem_diff[wrop_pkg::SumW-1:0]
                                                    : rem_shift[wrop_pkg::SumW-1:0];

  assign status_o.div_last = (div_cnt_q == DivLast);

  // The walk ends on the first entry whose weight exceeds the residue, or on the last entry.
  assign walk_hit           = (rem_q < {{(wrop_pkg::SumW-wrop_pkg::WeightBits){1'b0}}, weight});
  assign status_o.walk_done = walk_hit || entry_last;

  // Round-robin position, with a stale index falling back to entry zero.
  assign seq_cur = ({1'b0, seq_q} < count) ? seq_q : '0;
  assign seq_inc = {1'b0, seq_cur} + 4'd1;

  assign status_o.out_free = !out_valid_q || !out_stall_i;

  // Configuration and round-robin state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q      <= 1'b0;
      play_first_q   <= 1'b0;
      randomize_q    <= 1'b0;
      entry_count_q  <= '0;
      use_weights_q  <= 1'b0;
      weight_table_q <= '0;
      seq_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          wrop_pkg::CFG_ENABLED:      enabled_q      <= cfg_data_i[0];
          wrop_pkg::CFG_PLAY_FIRST:   play_first_q   <= cfg_data_i[0];
          wrop_pkg::CFG_RANDOMIZE:    randomize_q    <= cfg_data_i[0];
          wrop_pkg::CFG_ENTRY_COUNT:  entry_count_q  <= cfg_data_i[wrop_pkg::CountW-1:0];
          wrop_pkg::CFG_USE_WEIGHTS:  use_weights_q  <= cfg_data_i[0];
          wrop_pkg::CFG_WEIGHT_TABLE: weight_table_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      if (cmd_i.res_sel == wrop_pkg::RES_SEQ) begin
        seq_q <= (seq_inc == count) ? '0 : seq_inc[wrop_pkg::IdxW-1:0];
      end
    end
  end

  // Sum, remainder and walk registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rand_q    <= random_value_i;
      sum_q     <= '0;
      rem_q     <= '0;
      div_cnt_q <= '0;
      ent_q     <= '0;
    end
    if (cmd_i.sum_step) begin
      sum_q <= sum_q + {{(wrop_pkg::SumW-wrop_pkg::WeightBits){1'b0}}, weight};
      ent_q <= entry_last ? '0 : ent_q + 3'd1;
    end
    if (cmd_i.div_step) begin
      rand_q    <= {rand_q[wrop_pkg::RandW-2:0], 1'b0};
      rem_q     <= rem_next;
      div_cnt_q <= div_cnt_q + 5'd1;
    end
    if (cmd_i.walk_step && !walk_hit) begin
      rem_q <= rem_q - {{(wrop_pkg::SumW-wrop_pkg::WeightBits){1'b0}}, weight};
      ent_q <= ent_q + 3'd1;
    end
  end

  // Result of the current item.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.res_sel)
      wrop_pkg::RES_NONE: begin
        res_valid_q <= 1'b0;
        res_idx_q   <= '0;
      end
      wrop_pkg::RES_ZERO: begin
        res_valid_q <= 1'b1;
        res_idx_q   <= '0;
      end
      wrop_pkg::RES_SEQ: begin
        res_valid_q <= 1'b1;
        res_idx_q   <= seq_cur;
      end
      default: begin
      end
    endcase
    if (cmd_i.div_step && status_o.div_last) begin
      res_valid_q <= 1'b1;
      res_idx_q   <= rem_next[wrop_pkg::IdxW-1:0];
    end
    if (cmd_i.walk_step) begin
      res_valid_q <= walk_hit;
      res_idx_q   <= walk_hit ? ent_q : '0;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      pick_valid_q <= res_valid_q;
      pick_index_q <= res_idx_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign pick_valid_o = pick_valid_q;
  assign pick_index_o = pick_index_q;

endmodule
